// ===== design/aslru_pkg.sv =====
// Shared types and constants for the LRU cache-set block.
// No dependencies; assoc_set_lru_timestamp and aslru_ctrl import this package.
package aslru_pkg;

    localparam int TAG_IN_W  = 20;   // tag field width on the stream
    localparam int STAMP_W   = 32;   // recency stamp width
    localparam int WAY_OUT_W = 3;    // way field width on the stream
    localparam int S_TDATA_W = 56;   // tag + stamp, padded to bytes
    localparam int M_TDATA_W = 8;    // hit + way + replaced, padded to bytes

    typedef enum logic {
        ACT_LOOKUP = 1'b0,
        ACT_FILL   = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic                 replaced;
    } result_t;

endpackage

// ===== design/assoc_set_lru_timestamp.sv =====
// One cache set of WAYS lines with time-stamp LRU replacement. A request is
// a lookup or a fill; each request returns exactly one result. Tags and
// stamps live in a single-port-read line RAM scanned one way per cycle, so a
// request that scans (any lookup, or a fill into a full set) occupies the
// block until its scan ends, while a fill into a free line skips the scan.
// Results pass through an output register, so a new request is taken while
// the previous result waits. Uses aslru_pkg, aslru_ctrl and aslru_line_mem.
module assoc_set_lru_timestamp #(
    parameter int WAYS     = 8,
    parameter int TAG_BITS = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [aslru_pkg::S_TDATA_W-1:0]   s_tdata,  // tag[19:0], stamp[51:20], zero pad
    input  logic [0:0]                        s_tuser,  // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [aslru_pkg::M_TDATA_W-1:0]   m_tdata   // hit[0], way[3:1], replaced[4], pad
);

    import aslru_pkg::*;

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int DW    = TAG_BITS + STAMP_W;

    logic [TAG_BITS-1:0] key;
    logic [STAMP_W-1:0]  stamp;
    result_t             res;
    logic                res_valid;
    logic                res_ready;
    logic                mem_we;
    logic [WAY_W-1:0]    mem_waddr;
    logic [DW-1:0]       mem_wdata;
    logic                mem_re;
    logic [WAY_W-1:0]    mem_raddr;
    logic [DW-1:0]       mem_rdata;
    logic                out_valid_reg;
    result_t             out_res_reg;

    // only the low TAG_BITS of the tag take part
    for (genvar b = 0; b < TAG_BITS; b++)
    begin : g_key
        if (b < TAG_IN_W)
        begin : g_bit
            assign key[b] = s_tdata[b];
        end
        else
        begin : g_zero
            assign key[b] = 1'b0;
        end
    end

    assign stamp = s_tdata[TAG_IN_W+STAMP_W-1:TAG_IN_W];

    aslru_ctrl #(
        .WAYS     (WAYS),
        .TAG_BITS (TAG_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .action    (action_t'(s_tuser[0])),
        .key       (key),
        .stamp     (stamp),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    aslru_line_mem #(
        .DEPTH (WAYS),
        .AW    (WAY_W),
        .DW    (DW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg.replaced, out_res_reg.way, out_res_reg.hit};

endmodule

// ===== design/aslru_line_mem.sv =====
// Line store of the cache set: one {stamp, tag} word per way.
// Simple dual-port synchronous RAM, one write and one registered read.
module aslru_line_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 52
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/aslru_ctrl.sv =====
// Request sequencer: scans the line store one way per cycle, picks the hit,
// a free way or the LRU victim, and writes the line on a hit or a fill. Uses aslru_pkg.
module aslru_ctrl #(
    parameter int WAYS     = 8,
    parameter int TAG_BITS = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  aslru_pkg::action_t          action,
    input  logic [TAG_BITS-1:0]         key,
    input  logic [aslru_pkg::STAMP_W-1:0] stamp,
    output logic                        res_valid,
    input  logic                        res_ready,
    output aslru_pkg::result_t          res,
    output logic                        mem_we,
    output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] mem_waddr,
    output logic [TAG_BITS+aslru_pkg::STAMP_W-1:0]     mem_wdata,
    output logic                        mem_re,
    output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] mem_raddr,
    input  logic [TAG_BITS+aslru_pkg::STAMP_W-1:0]     mem_rdata
);

    import aslru_pkg::*;

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [WAY_W-1:0] LAST = WAY_W'(WAYS - 1);

    state_t              state_reg, state_next;
    action_t             act_reg, act_next;
    logic [TAG_BITS-1:0] key_reg, key_next;
    logic [STAMP_W-1:0]  stamp_reg, stamp_next;
    logic [WAY_W-1:0]    cnt_reg, cnt_next;
    logic                issue_reg, issue_next;
    logic                dvld_reg, dvld_next;
    logic [WAY_W-1:0]    idx_reg, idx_next;
    logic [STAMP_W-1:0]  min_reg, min_next;
    logic [WAY_W-1:0]    victim_reg, victim_next;
    logic [WAY_W-1:0]    way_reg, way_next;
    logic                hit_reg, hit_next;
    logic                repl_reg, repl_next;
    logic                wr_reg, wr_next;
    logic [WAYS-1:0]     valid_reg, valid_next;

    logic [WAY_W-1:0]    first_inv;
    logic                any_inv;
    logic [TAG_BITS-1:0] rd_tag;
    logic [STAMP_W-1:0]  rd_stamp;
    logic                match;
    logic                last_d;
    logic                less;
    logic                scan_done;
    logic                commit;

    assign rd_tag   = mem_rdata[TAG_BITS-1:0];
    assign rd_stamp = mem_rdata[TAG_BITS+STAMP_W-1:TAG_BITS];
    assign any_inv  = ~&valid_reg;

    // lowest-numbered invalid way
    always_comb
    begin
        first_inv = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                first_inv = WAY_W'(i);
            end
        end
    end

    assign match  = dvld_reg && valid_reg[idx_reg] && (rd_tag == key_reg);
    assign last_d = (idx_reg == LAST);
    // strict less keeps the lowest index on a tie
    assign less   = (idx_reg == '0) || (rd_stamp < min_reg);
    assign scan_done = dvld_reg && ((act_reg == ACT_LOOKUP) ? (match || last_d) : last_d);
    assign commit = (state_reg == ST_DONE) && res_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    state_next = (action == ACT_FILL && any_inv) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_ready   = (state_reg == ST_IDLE);
        res_valid = (state_reg == ST_DONE);
        mem_re    = (state_reg == ST_SCAN) && issue_reg;
        mem_raddr = cnt_reg;
        mem_we    = commit && wr_reg;
        mem_waddr = way_reg;
        mem_wdata = {stamp_reg, key_reg};
    end

    // datapath
    always_comb
    begin
        act_next    = act_reg;
        key_next    = key_reg;
        stamp_next  = stamp_reg;
        cnt_next    = cnt_reg;
        issue_next  = issue_reg;
        dvld_next   = dvld_reg;
        idx_next    = idx_reg;
        min_next    = min_reg;
        victim_next = victim_reg;
        way_next    = way_reg;
        hit_next    = hit_reg;
        repl_next   = repl_reg;
        wr_next     = wr_reg;
        valid_next  = valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    act_next   = action;
                    key_next   = key;
                    stamp_next = stamp;
                    cnt_next   = '0;
                    issue_next = 1'b1;
                    dvld_next  = 1'b0;
                    way_next   = first_inv;
                    hit_next   = 1'b0;
                    repl_next  = 1'b0;
                    wr_next    = (action == ACT_FILL);
                end
            end
            ST_SCAN:
            begin
                if (issue_reg)
                begin
                    if (cnt_reg != LAST)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    issue_next = (cnt_reg != LAST);
                end
                dvld_next = issue_reg;
                idx_next  = cnt_reg;
                if (dvld_reg && act_reg == ACT_FILL && less)
                begin
                    min_next    = rd_stamp;
                    victim_next = idx_reg;
                end
                if (scan_done)
                begin
                    if (act_reg == ACT_LOOKUP)
                    begin
                        hit_next = match;
                        way_next = match ? idx_reg : '0;
                        wr_next  = match;
                    end
                    else
                    begin
                        way_next  = less ? idx_reg : victim_reg;
                        repl_next = 1'b1;
                        wr_next   = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (commit && wr_reg)
                begin
                    valid_next[way_reg] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            issue_reg <= 1'b0;
            dvld_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            dvld_reg  <= dvld_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        key_reg    <= key_next;
        stamp_reg  <= stamp_next;
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
        min_reg    <= min_next;
        victim_reg <= victim_next;
        way_reg    <= way_next;
        hit_reg    <= hit_next;
        repl_reg   <= repl_next;
        wr_reg     <= wr_next;
    end

    // way field carries the low bits of the index
    for (genvar b = 0; b < WAY_OUT_W; b++)
    begin : g_way
        if (b < WAY_W)
        begin : g_bit
            assign res.way[b] = way_reg[b];
        end
        else
        begin : g_zero
            assign res.way[b] = 1'b0;
        end
    end

    assign res.hit      = hit_reg;
    assign res.replaced = repl_reg;

endmodule
